@@ src/lgsq_pkg.sv @@
package lgsq_pkg;

    // Grid and counter sizing.
    localparam int MAX_AXIS_POINTS = 8;
    localparam int COUNT_WIDTH     = 8;

    localparam int NUM_LABELS = 4096;
    localparam int LIX_W      = 12;

    // Field widths.
    localparam int VAL_W  = 16;
    localparam int CFG_W  = 15;
    localparam int QUOTA_W = 8;
    localparam int OUT_COUNT_W = 8;

    // Axis index and point count widths.
    localparam int IDX_W = (MAX_AXIS_POINTS > 1) ? $clog2(MAX_AXIS_POINTS) : 1;
    localparam int PT_W  = $clog2(MAX_AXIS_POINTS + 1);

    // Width of the threshold compares inside a lane.
    localparam int THR_W  = CFG_W + $clog2(2 * MAX_AXIS_POINTS);
    localparam int LANE_W = (THR_W > VAL_W + 1) ? THR_W : VAL_W + 1;

    // Width used when the counter is compared against the quota.
    localparam int CMP_W = (COUNT_WIDTH > QUOTA_W) ? COUNT_WIDTH : QUOTA_W;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_SHIFT_HALF = 3'd0;
    localparam logic [2:0] REG_SHIFT_STEP = 3'd1;
    localparam logic [2:0] REG_SCALE_HALF = 3'd2;
    localparam logic [2:0] REG_SCALE_STEP = 3'd3;
    localparam logic [2:0] REG_ROT_HALF   = 3'd4;
    localparam logic [2:0] REG_ROT_STEP   = 3'd5;
    localparam logic [2:0] REG_QUOTA      = 3'd6;

    typedef struct packed {
        logic signed [VAL_W-1:0] shift_x;
        logic signed [VAL_W-1:0] shift_y;
        logic signed [VAL_W-1:0] scale_offset;
        logic signed [VAL_W-1:0] rotation_deg;
    } in_item_t;

    typedef struct packed {
        logic [LIX_W-1:0]       label_index;
        logic [OUT_COUNT_W-1:0] count_after;
        logic                   just_filled;
        logic                   already_full;
    } out_item_t;

    // Snapped indices of one pose and the point counts that weight them.
    typedef struct packed {
        logic [IDX_W-1:0] ix;
        logic [IDX_W-1:0] iy;
        logic [IDX_W-1:0] isc;
        logic [IDX_W-1:0] ir;
        logic [PT_W-1:0]  ns;
        logic [PT_W-1:0]  nsc;
    } snap_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_ctrl_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_UPDATE
    } state_t;

endpackage

@@ src/lgsq_axis_lane.sv @@
module lgsq_axis_lane (
    input  logic signed [lgsq_pkg::VAL_W-1:0] value,
    input  logic [lgsq_pkg::CFG_W-1:0]        half,
    input  logic [lgsq_pkg::CFG_W-1:0]        step,
    output logic [lgsq_pkg::IDX_W-1:0]        idx,
    output logic [lgsq_pkg::PT_W-1:0]         npts
);
    import lgsq_pkg::*;

    // The offset from the lowest grid point spans a signed 16-bit value plus a
    // 15-bit half range, so it needs two bits above the value width.
    logic [VAL_W+1:0]  d;
    logic              d_pos;
    logic [LANE_W-1:0] two_d;
    logic [LANE_W-1:0] two_half;

    // Grid point k is reached when 2*d lies above (2k-1)*step, and it exists
    // when k*step fits inside the full span. Both tests are monotonic in k,
    // so counting the points that pass both gives the clamped nearest index.
    always_comb
    begin
        logic [LANE_W-1:0] thr_round;
        logic [LANE_W-1:0] thr_fit;
        logic [PT_W-1:0]   idx_acc;
        logic [PT_W-1:0]   fit_acc;
        logic              fit;

        d        = {{2{value[VAL_W-1]}}, value} + {3'b000, half};
        d_pos    = !d[VAL_W+1] && (d != '0);
        two_d    = LANE_W'({d[VAL_W:0], 1'b0});
        two_half = LANE_W'({half, 1'b0});
        idx_acc  = '0;
        fit_acc  = '0;
        for (int k = 1; k < MAX_AXIS_POINTS; k++)
        begin
            thr_round = LANE_W'(step) * LANE_W'(2 * k - 1);
            thr_fit   = LANE_W'(step) * LANE_W'(k);
            fit       = (thr_fit <= two_half);
            if (fit)
            begin
                fit_acc = fit_acc + 1'b1;
            end
            if (fit && d_pos && (two_d > thr_round))
            begin
                idx_acc = idx_acc + 1'b1;
            end
        end
        if (step == '0)
        begin
            idx  = '0;
            npts = PT_W'(1);
        end
        else
        begin
            idx  = idx_acc[IDX_W-1:0];
            npts = fit_acc + 1'b1;
        end
    end

endmodule

@@ src/lgsq_index_merge.sv @@
module lgsq_index_merge (
    input  logic                         clk,
    input  logic                         load,
    input  lgsq_pkg::snap_t              snap,
    output logic [lgsq_pkg::LIX_W-1:0]   label_index
);
    import lgsq_pkg::*;

    logic [LIX_W-1:0] head_reg;
    logic [LIX_W-1:0] head_next;
    logic [LIX_W-1:0] weight_reg;
    logic [LIX_W-1:0] weight_next;
    logic [LIX_W-1:0] iy_reg;
    logic [LIX_W-1:0] isc_reg;
    logic [LIX_W-1:0] nsc_reg;

    // First step folds rotation and x together and forms the weight of that
    // pair; the second step adds the y and scale terms. Arithmetic wraps at
    // the label count, which gives the low index bits directly.
    assign head_next   = LIX_W'(snap.ir) * LIX_W'(snap.ns) + LIX_W'(snap.ix);
    assign weight_next = LIX_W'(snap.ns) * LIX_W'(snap.nsc);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            head_reg   <= head_next;
            weight_reg <= weight_next;
            iy_reg     <= LIX_W'(snap.iy);
            isc_reg    <= LIX_W'(snap.isc);
            nsc_reg    <= LIX_W'(snap.nsc);
        end
    end

    assign label_index = head_reg * weight_reg + iy_reg * nsc_reg + isc_reg;

endmodule

@@ src/lgsq_count_store.sv @@
module lgsq_count_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lgsq_pkg::store_ctrl_t         ctrl,
    input  logic [lgsq_pkg::LIX_W-1:0]    rd_addr,
    input  logic [lgsq_pkg::QUOTA_W-1:0]  quota,
    output logic                          clearing,
    output lgsq_pkg::out_item_t           res
);
    import lgsq_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [NUM_LABELS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [LIX_W-1:0]       addr_reg;
    logic [LIX_W-1:0]       clr_addr_reg;
    logic [LIX_W-1:0]       clr_addr_next;
    logic                   clearing_reg;
    logic                   clearing_next;

    logic [COUNT_WIDTH-1:0] c_inc;
    logic [COUNT_WIDTH-1:0] c_new;
    logic [CMP_W-1:0]       c_ext;
    logic [CMP_W-1:0]       c_new_ext;
    logic [CMP_W-1:0]       c_inc_ext;
    logic [CMP_W-1:0]       quota_ext;
    logic                   can_inc;

    logic                   we;
    logic [LIX_W-1:0]       wa;
    logic [COUNT_WIDTH-1:0] wd;

    // Clearing sweep after reset, one counter per cycle.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    assign clearing = clearing_reg;

    // Counter update on the word read in the previous cycle.
    always_comb
    begin
        c_ext     = CMP_W'(rd_data_reg);
        quota_ext = CMP_W'(quota);
        can_inc   = (c_ext < quota_ext) && (rd_data_reg != '1);
        c_inc     = rd_data_reg + 1'b1;
        c_inc_ext = CMP_W'(c_inc);
        c_new     = can_inc ? c_inc : rd_data_reg;
        c_new_ext = CMP_W'(c_new);

        res.label_index  = addr_reg;
        res.count_after  = c_new_ext[OUT_COUNT_W-1:0];
        res.just_filled  = can_inc && (c_inc_ext == quota_ext);
        res.already_full = !can_inc;
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end
        else
        begin
            we = ctrl.wr_en && can_inc;
            wa = addr_reg;
            wd = c_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
    end

endmodule

@@ src/label_grid_sample_quota_unit.sv @@
// Sequence: an accepted transfer loads the merge registers, its label counter
// is read in ST_INDEX and written back in ST_UPDATE, then its result is
// registered and strobed on done. A new item is taken during that write-back.
// Reset: control and configuration registers clear at once; a sweep then
// zeroes the 4096 counters with busy held high. The receiver cannot stall,
// so results never wait.
module label_grid_sample_quota_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lgsq_pkg::in_item_t             item,
    output logic                           done,
    output lgsq_pkg::out_item_t            result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lgsq_pkg::ADDR_W-1:0]    paddr,
    input  logic [lgsq_pkg::DATA_W-1:0]    pwdata,
    output logic [lgsq_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import lgsq_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]   shift_half_reg;
    logic [CFG_W-1:0]   shift_step_reg;
    logic [CFG_W-1:0]   scale_half_reg;
    logic [CFG_W-1:0]   scale_step_reg;
    logic [CFG_W-1:0]   rot_half_reg;
    logic [CFG_W-1:0]   rot_step_reg;
    logic [QUOTA_W-1:0] quota_reg;
    logic               cfg_write;

    // Control.
    state_t      state_reg;
    state_t      state_next;
    logic        accept;
    logic        done_reg;
    logic        done_next;
    out_item_t   result_reg;
    store_ctrl_t store_ctrl;
    logic        clearing;
    out_item_t   store_res;

    // Datapath.
    snap_t            snap;
    logic [LIX_W-1:0] label_index;

    // The configuration port has no wait states; a write lands at the edge
    // that ends its access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_half_reg <= '0;
            shift_step_reg <= '0;
            scale_half_reg <= '0;
            scale_step_reg <= '0;
            rot_half_reg   <= '0;
            rot_step_reg   <= '0;
            quota_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[ADDR_W-1:2])
                REG_SHIFT_HALF: shift_half_reg <= pwdata[CFG_W-1:0];
                REG_SHIFT_STEP: shift_step_reg <= pwdata[CFG_W-1:0];
                REG_SCALE_HALF: scale_half_reg <= pwdata[CFG_W-1:0];
                REG_SCALE_STEP: scale_step_reg <= pwdata[CFG_W-1:0];
                REG_ROT_HALF:   rot_half_reg   <= pwdata[CFG_W-1:0];
                REG_ROT_STEP:   rot_step_reg   <= pwdata[CFG_W-1:0];
                REG_QUOTA:      quota_reg      <= pwdata[QUOTA_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_SHIFT_HALF: prdata = DATA_W'(shift_half_reg);
            REG_SHIFT_STEP: prdata = DATA_W'(shift_step_reg);
            REG_SCALE_HALF: prdata = DATA_W'(scale_half_reg);
            REG_SCALE_STEP: prdata = DATA_W'(scale_step_reg);
            REG_ROT_HALF:   prdata = DATA_W'(rot_half_reg);
            REG_ROT_STEP:   prdata = DATA_W'(rot_step_reg);
            REG_QUOTA:      prdata = DATA_W'(quota_reg);
            default:        prdata = '0;
        endcase
    end

    // Four snapping lanes, one per pose component, work on the transfer as it
    // is accepted. The x and y lanes share the shift grid.
    lgsq_axis_lane u_lane_x (
        .value (item.shift_x),
        .half  (shift_half_reg),
        .step  (shift_step_reg),
        .idx   (snap.ix),
        .npts  (snap.ns)
    );

    lgsq_axis_lane u_lane_y (
        .value (item.shift_y),
        .half  (shift_half_reg),
        .step  (shift_step_reg),
        .idx   (snap.iy),
        .npts  ()
    );

    lgsq_axis_lane u_lane_scale (
        .value (item.scale_offset),
        .half  (scale_half_reg),
        .step  (scale_step_reg),
        .idx   (snap.isc),
        .npts  (snap.nsc)
    );

    lgsq_axis_lane u_lane_rot (
        .value (item.rotation_deg),
        .half  (rot_half_reg),
        .step  (rot_step_reg),
        .idx   (snap.ir),
        .npts  ()
    );

    // The merging stage registers the lane results at accept and forms the
    // mixed-radix label index during the following cycle.
    lgsq_index_merge u_merge (
        .clk         (clk),
        .load        (accept),
        .snap        (snap),
        .label_index (label_index)
    );

    lgsq_count_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (store_ctrl),
        .rd_addr  (label_index),
        .quota    (quota_reg),
        .clearing (clearing),
        .res      (store_res)
    );

    // The block takes a new transfer while the previous one writes its
    // counter back: the new label is read in ST_INDEX, after that write has
    // landed, so a repeated label always sees the updated count.
    assign busy   = (state_reg == ST_CLEAR) || (state_reg == ST_INDEX);
    assign accept = start && !busy;

    always_comb
    begin
        state_next       = state_reg;
        store_ctrl.rd_en = 1'b0;
        store_ctrl.wr_en = 1'b0;
        done_next        = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (!clearing)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                store_ctrl.rd_en = 1'b1;
                state_next       = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                store_ctrl.wr_en = 1'b1;
                done_next        = 1'b1;
                state_next       = accept ? ST_INDEX : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // The result register holds a finished result through its single strobe
    // cycle and after it, while the next transfer already works on its label.
    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            result_reg <= store_res;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // Every accepted transfer yields its result strobe once it has passed ST_INDEX and ST_UPDATE.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted transfer did not produce a result on time");

    // A result is only strobed after a counter update cycle.
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPDATE))
        else $error("result strobe without a counter update");

    // A sample either counts or finds its label full, never both.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.just_filled && result.already_full))
        else $error("just_filled and already_full both set");

    // No transfer is taken while the counter sweep is still running.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !accept)
        else $error("transfer accepted during counter clearing");
`endif

endmodule
